// File: design/slot_free_list_allocator_unit_assert.svh
// Assertion shorthands for the slot allocator; all sample on clk and skip reset.
`ifndef SLOT_FREE_LIST_ALLOCATOR_UNIT_ASSERT_SVH
`define SLOT_FREE_LIST_ALLOCATOR_UNIT_ASSERT_SVH

// Condition that holds at every edge.
`define SFLA_ASSERT_ALWAYS(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("slot allocator check failed");

// Same-cycle implication.
`define SFLA_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("slot allocator check failed");

// Next-cycle implication.
`define SFLA_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("slot allocator check failed");

`endif

// File: design/sfla_pkg.sv
`timescale 1ns / 1ps

package sfla_pkg;

	localparam int NUM_SLOTS_DEF = 32;
	localparam int LIST_MAX      = 32;

	localparam int ID_W       = 6;
	localparam int REQ_W      = 3;
	localparam int SID_W      = 8;
	localparam int ST_W       = 3;
	localparam int ADDR_W     = 32;
	localparam int VER_W      = 32;
	localparam int SIZE_W     = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;
	localparam int CNT_W      = $clog2(LIST_MAX + 1);

	localparam logic [SIZE_W-1:0] SLOT_SIZE_RST  = SIZE_W'(64);
	localparam logic [ID_W-1:0]   SLOT_COUNT_RST = ID_W'(32);
	localparam logic [ADDR_W-1:0] BASE_ADDR_RST  = '0;

	typedef enum logic [REQ_W-1:0] {
		REQ_ALLOC  = 3'd0,
		REQ_FREE   = 3'd1,
		REQ_LOOKUP = 3'd2,
		REQ_LIST   = 3'd3,
		REQ_REINIT = 3'd4
	} req_kind_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK      = 3'd0,
		ST_NOMEM   = 3'd1,
		ST_INVALID = 3'd2,
		ST_FREE    = 3'd3,
		ST_NONE    = 3'd4
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SLOT_SIZE  = 2'd0,
		REG_SLOT_COUNT = 2'd1,
		REG_BASE_ADDR  = 2'd2
	} cfg_reg_t;

	// Controller to datapath.
	typedef struct packed {
		logic start;   // capture request, issue first table read
		logic exec;    // finish a single-entry request and load its result
		logic scan;    // process one listed entry
		logic finish;  // load the closing list result
	} cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic is_single;
		logic is_list;
		logic cnt_zero;
		logic out_free;
		logic scan_ok;
		logic scan_last;
	} sts_t;

endpackage

// File: design/sfla_req_if.sv
`timescale 1ns / 1ps

interface sfla_req_if;
	import sfla_pkg::*;

	logic             valid;
	logic             ready;
	logic [REQ_W-1:0] req_type;
	logic [SID_W-1:0] slot_id;

	modport source (output valid, output req_type, output slot_id, input ready);
	modport sink (input valid, input req_type, input slot_id, output ready);

endinterface

// File: design/sfla_rsp_if.sv
`timescale 1ns / 1ps

interface sfla_rsp_if;
	import sfla_pkg::*;

	logic              valid;
	logic              ready;
	logic [ST_W-1:0]   status;
	logic [ID_W-1:0]   slot_id_res;
	logic [ADDR_W-1:0] address;
	logic [VER_W-1:0]  version;
	logic              last;

	modport source (output valid, output status, output slot_id_res, output address,
		output version, output last, input ready);
	modport sink (input valid, input status, input slot_id_res, input address,
		input version, input last, output ready);

endinterface

// File: design/sfla_dpath.sv
`timescale 1ns / 1ps

module sfla_dpath #(
	parameter int NUM_SLOTS = sfla_pkg::NUM_SLOTS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [sfla_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sfla_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic [sfla_pkg::REQ_W-1:0]      req_type,
	input  logic [sfla_pkg::SID_W-1:0]      slot_id,
	input  sfla_pkg::cmd_t                  cmd,
	output sfla_pkg::sts_t                  sts,
	sfla_rsp_if.source                      rsp
);
	import sfla_pkg::*;

	localparam int TW = $clog2(NUM_SLOTS + 1);
	localparam int PW = SIZE_W + ID_W;
	localparam logic [ID_W-1:0] NSLOT = ID_W'(NUM_SLOTS);

	logic [SIZE_W-1:0] slot_size_q;
	logic [ID_W-1:0]   slot_count_q;
	logic [ADDR_W-1:0] base_q;

	logic [REQ_W-1:0]  req_q;
	logic [SID_W-1:0]  id_q;
	logic [ID_W-1:0]   head_q;
	logic [VER_W-1:0]  ver_q;

	// Slot link table; an entry never written since reset or reinit reads as index plus one.
	logic [ID_W-1:0]   mem [0:NUM_SLOTS];
	logic [NUM_SLOTS:0] vld_q;
	logic [ID_W-1:0]   rd_q;
	logic              rdv_q;
	logic [TW-1:0]     rda_q;

	logic [TW-1:0]     scan_q;
	logic [ID_W-1:0]   pend_q;
	logic              pend_v_q;
	logic [CNT_W-1:0]  lcnt_q;

	logic              out_v_q;
	logic [ST_W-1:0]   out_st_q;
	logic [ID_W-1:0]   out_id_q;
	logic [ADDR_W-1:0] out_addr_q;
	logic [VER_W-1:0]  out_ver_q;
	logic              out_last_q;

	logic [ID_W-1:0]   n;
	logic [ID_W-1:0]   rval;
	logic              head_ok, in_id_ok, id_ok, used, out_free;
	logic [CNT_W-1:0]  lcnt_nx;
	logic              rd_en;
	logic [TW-1:0]     rd_addr;
	logic              wr_en;
	logic [TW-1:0]     wr_addr;
	logic [ID_W-1:0]   wr_data;
	logic              head_we, clr_vld, ver_bump;
	logic [ID_W-1:0]   head_nx;
	logic              load;
	logic [ST_W-1:0]   ld_st;
	logic [ID_W-1:0]   ld_id;
	logic [ADDR_W-1:0] ld_addr;
	logic              ld_last;
	logic [ID_W-1:0]   mul_id;
	logic [PW-1:0]     prod;
	logic [ADDR_W-1:0] slot_addr;

	assign n        = (slot_count_q > NSLOT) ? NSLOT : slot_count_q;
	assign rval     = rdv_q ? rd_q : (ID_W'(rda_q) + ID_W'(1));
	assign head_ok  = (head_q != '0) && (head_q <= n);
	assign in_id_ok = (slot_id != '0) && (slot_id <= SID_W'(n));
	assign id_ok    = (id_q != '0) && (id_q <= SID_W'(n));
	assign used     = (rval == '0);
	assign out_free = !out_v_q || rsp.ready;
	assign lcnt_nx  = lcnt_q + CNT_W'(used);

	assign mul_id    = (req_q == REQ_ALLOC) ? head_q : id_q[ID_W-1:0];
	assign prod      = PW'(slot_size_q) * PW'(mul_id - ID_W'(1));
	assign slot_addr = base_q + ADDR_W'(prod);

	always_comb begin
		sts.is_single = (req_type == REQ_ALLOC) || (req_type == REQ_FREE) ||
			(req_type == REQ_LOOKUP) || (req_type == REQ_REINIT);
		sts.is_list   = (req_type == REQ_LIST);
		sts.cnt_zero  = (n == '0);
		sts.out_free  = out_free;
		sts.scan_ok   = !(used && pend_v_q) || out_free;
		sts.scan_last = (ID_W'(scan_q) == n) || (lcnt_nx == CNT_W'(LIST_MAX));
	end

	// Table read port
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		if (cmd.start) begin
			rd_en = 1'b1;
			case (req_type)
				REQ_ALLOC: rd_addr = head_ok ? head_q[TW-1:0] : '0;
				REQ_FREE, REQ_LOOKUP: rd_addr = in_id_ok ? slot_id[TW-1:0] : '0;
				REQ_LIST: rd_addr = TW'(1);
				default: rd_en = 1'b0;
			endcase
		end else if (cmd.scan && !sts.scan_last) begin
			rd_en   = 1'b1;
			rd_addr = scan_q + TW'(1);
		end
	end

	// Request execution and result selection
	always_comb begin
		wr_en    = 1'b0;
		wr_addr  = '0;
		wr_data  = '0;
		head_we  = 1'b0;
		head_nx  = head_q;
		clr_vld  = 1'b0;
		ver_bump = 1'b0;
		load     = 1'b0;
		ld_st    = ST_OK;
		ld_id    = '0;
		ld_addr  = '0;
		ld_last  = 1'b1;
		if (cmd.exec) begin
			load = 1'b1;
			case (req_q)
				REQ_ALLOC: begin
					if (head_ok) begin
						wr_en    = 1'b1;
						wr_addr  = head_q[TW-1:0];
						head_we  = 1'b1;
						head_nx  = rval;
						ver_bump = 1'b1;
						ld_id    = head_q;
						ld_addr  = slot_addr;
					end else begin
						ld_st = ST_NOMEM;
					end
				end
				REQ_FREE: begin
					if (!id_ok) begin
						ld_st = ST_INVALID;
					end else begin
						// a slot already on the list is left alone
						if (used) begin
							wr_en   = 1'b1;
							wr_addr = id_q[TW-1:0];
							wr_data = head_q;
							head_we = 1'b1;
							head_nx = id_q[ID_W-1:0];
						end
						ver_bump = 1'b1;
					end
				end
				REQ_LOOKUP: begin
					if (!id_ok) begin
						ld_st = ST_INVALID;
					end else if (!used) begin
						ld_st = ST_FREE;
					end else begin
						ld_addr = slot_addr;
					end
				end
				REQ_REINIT: begin
					clr_vld = 1'b1;
					head_we = 1'b1;
					head_nx = ID_W'(1);
				end
				default: load = 1'b0;
			endcase
		end else if (cmd.scan) begin
			// emit the held id once a later used slot proves it is not the final one
			if (used && pend_v_q) begin
				load    = 1'b1;
				ld_id   = pend_q;
				ld_last = 1'b0;
			end
		end else if (cmd.finish) begin
			load = 1'b1;
			if (pend_v_q) begin
				ld_id = pend_q;
			end else begin
				ld_st = ST_NONE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_size_q  <= SLOT_SIZE_RST;
			slot_count_q <= SLOT_COUNT_RST;
			base_q       <= BASE_ADDR_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SLOT_SIZE:  slot_size_q  <= cfg_wdata[SIZE_W-1:0];
				REG_SLOT_COUNT: slot_count_q <= cfg_wdata[ID_W-1:0];
				REG_BASE_ADDR:  base_q       <= cfg_wdata[ADDR_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q   <= ID_W'(1);
			ver_q    <= '0;
			vld_q    <= '0;
			scan_q   <= '0;
			pend_v_q <= 1'b0;
			lcnt_q   <= '0;
			out_v_q  <= 1'b0;
		end else begin
			if (head_we) head_q <= head_nx;
			if (ver_bump) ver_q <= ver_q + VER_W'(1);
			if (clr_vld) begin
				vld_q <= '0;
			end else if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (cmd.start) begin
				scan_q   <= TW'(1);
				pend_v_q <= 1'b0;
				lcnt_q   <= '0;
			end else if (cmd.scan) begin
				if (used) begin
					pend_v_q <= 1'b1;
					lcnt_q   <= lcnt_nx;
				end
				if (!sts.scan_last) scan_q <= scan_q + TW'(1);
			end
			if (load) begin
				out_v_q <= 1'b1;
			end else if (rsp.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		if (rd_en) begin
			rd_q  <= mem[rd_addr];
			rdv_q <= vld_q[rd_addr];
			rda_q <= rd_addr;
		end
		if (cmd.start) begin
			req_q <= req_type;
			id_q  <= slot_id;
		end
		if (cmd.scan && used) pend_q <= ID_W'(scan_q);
		if (load) begin
			out_st_q   <= ld_st;
			out_id_q   <= ld_id;
			out_addr_q <= ld_addr;
			out_ver_q  <= ver_q + VER_W'(ver_bump);
			out_last_q <= ld_last;
		end
	end

	assign rsp.valid       = out_v_q;
	assign rsp.status      = out_st_q;
	assign rsp.slot_id_res = out_id_q;
	assign rsp.address     = out_addr_q;
	assign rsp.version     = out_ver_q;
	assign rsp.last        = out_last_q;

endmodule

// File: design/sfla_ctrl.sv
`timescale 1ns / 1ps

module sfla_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  sfla_pkg::sts_t sts,
	output sfla_pkg::cmd_t cmd
);
	import sfla_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_SCAN,
		S_FINISH
	} state_t;

	state_t state_q;
	logic   ready_q;

	always_comb begin
		cmd.start  = ready_q && in_valid;
		cmd.exec   = (state_q == S_EXEC) && sts.out_free;
		cmd.scan   = (state_q == S_SCAN) && sts.scan_ok;
		cmd.finish = (state_q == S_FINISH) && sts.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ready_q <= 1'b1;
		end else begin
			case (state_q)
				S_IDLE: begin
					// unknown request types are dropped without leaving idle
					if (in_valid && sts.is_single) begin
						state_q <= S_EXEC;
						ready_q <= 1'b0;
					end else if (in_valid && sts.is_list) begin
						state_q <= sts.cnt_zero ? S_FINISH : S_SCAN;
						ready_q <= 1'b0;
					end
				end
				S_EXEC: begin
					if (sts.out_free) begin
						state_q <= S_IDLE;
						ready_q <= 1'b1;
					end
				end
				S_SCAN: begin
					if (sts.scan_ok && sts.scan_last) state_q <= S_FINISH;
				end
				S_FINISH: begin
					if (sts.out_free) begin
						state_q <= S_IDLE;
						ready_q <= 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
					ready_q <= 1'b1;
				end
			endcase
		end
	end

	assign in_ready = ready_q;

endmodule

// File: design/slot_free_list_allocator_unit.sv
// Slot allocator over a linked free list of up to NUM_SLOTS slots. Alloc, free, lookup and
// reinit are each taken in an accept step that issues at most one read of the link table,
// then an exec step that, once the result register is free, writes at most one entry and
// loads the result; no new request is taken before that. A list request walks the table
// one entry per cycle while the result side does not stall. The link table resets through
// per-entry valid bits, so no clearing pass follows reset or reinit. Request types 5 to 7
// are accepted and dropped without a result.
`timescale 1ns / 1ps
`include "slot_free_list_allocator_unit_assert.svh"

module slot_free_list_allocator_unit #(
	parameter int NUM_SLOTS = sfla_pkg::NUM_SLOTS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	sfla_req_if.sink                        req,
	sfla_rsp_if.source                      rsp,
	input  logic                            cfg_we,
	input  logic [sfla_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sfla_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import sfla_pkg::*;

	cmd_t cmd;
	sts_t sts;
	logic ready;

	assign req.ready = ready;

	sfla_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	sfla_dpath #(
		.NUM_SLOTS (NUM_SLOTS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.req_type  (req.req_type),
		.slot_id   (req.slot_id),
		.cmd       (cmd),
		.sts       (sts),
		.rsp       (rsp)
	);

	`SFLA_ASSERT_ALWAYS(a_cmd_onehot, $onehot0(cmd))
	`SFLA_ASSERT_IMP(a_load_when_free, cmd.exec || cmd.finish, sts.out_free)
	`SFLA_ASSERT_NEXT(a_single_busy, req.valid && req.ready && sts.is_single, !req.ready)
	`SFLA_ASSERT_NEXT(a_exec_result, cmd.exec, rsp.valid)

endmodule

// File: bench/slot_free_list_allocator_unit_tb.sv
`timescale 1ns / 1ps

module slot_free_list_allocator_unit_tb;
	import sfla_pkg::*;

	localparam int TABLE_SLOTS = NUM_SLOTS_DEF;
	localparam logic [REQ_W-1:0] REQ_UNUSED_LO = REQ_W'(5);
	localparam logic [REQ_W-1:0] REQ_UNUSED_HI = REQ_W'(7);
	localparam int STALL_LIMIT = 4000;
	localparam int HOLD_CYCLES = 300;
	localparam int SETTLE_CYCLES = 12;
	localparam int TAIL_CYCLES = LIST_MAX + 20;
	localparam int ITEMS_PER_PHASE = 50;
	localparam int MAX_REPORTS = 40;

	typedef struct packed {
		status_t           status;
		logic [ID_W-1:0]   slot_id;
		logic [ADDR_W-1:0] address;
		logic [VER_W-1:0]  version;
		logic              last;
	} slot_result_t;

	class slot_pool_scoreboard;
		logic [ID_W-1:0]   links [0:TABLE_SLOTS];
		logic [VER_W-1:0]  change_count;
		logic [SIZE_W-1:0] slot_size;
		logic [ID_W-1:0]   slot_count;
		logic [ADDR_W-1:0] base_address;
		slot_result_t      due_results [$];
		int unsigned       errors;
		int unsigned       requests;
		int unsigned       results;
		int unsigned       longest_list;
		int unsigned       refused_allocs;

		function new();
			relink();
			change_count = '0;
			slot_size    = SLOT_SIZE_RST;
			slot_count   = SLOT_COUNT_RST;
			base_address = BASE_ADDR_RST;
		endfunction

		function void relink();
			for (int i = 0; i <= TABLE_SLOTS; i++)
				links[i] = ID_W'(i + 1);
		endfunction

		function int unsigned active_slots();
			return (slot_count > TABLE_SLOTS) ? TABLE_SLOTS : slot_count;
		endfunction

		function logic [ADDR_W-1:0] slot_address(int unsigned id);
			return base_address + ADDR_W'(slot_size) * ADDR_W'(id - 1);
		endfunction

		function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
			REG_SLOT_SIZE: slot_size = data[SIZE_W-1:0];
			REG_SLOT_COUNT: slot_count = data[ID_W-1:0];
			REG_BASE_ADDR: base_address = data[ADDR_W-1:0];
			default: ;
			endcase
		endfunction

		function void queue_result(status_t st, logic [ID_W-1:0] id, logic [ADDR_W-1:0] addr,
			logic last);
			slot_result_t r;
			r.status  = st;
			r.slot_id = id;
			r.address = addr;
			r.version = change_count;
			r.last    = last;
			due_results.push_back(r);
		endfunction

		// Predict the results of one accepted request and update the pool.
		function void note_request(logic [REQ_W-1:0] kind, logic [SID_W-1:0] id);
			int unsigned     n;
			int unsigned     listed;
			logic [ID_W-1:0] head;
			slot_result_t    r;
			n = active_slots();
			requests++;
			case (kind)
			REQ_ALLOC: begin
				head = links[0];
				if (head == '0 || head > n) begin
					refused_allocs++;
					queue_result(ST_NOMEM, '0, '0, 1'b1);
				end else begin
					links[0]    = links[head];
					links[head] = '0;
					change_count++;
					queue_result(ST_OK, head, slot_address(head), 1'b1);
				end
			end
			REQ_FREE: begin
				if (id == '0 || id > n) begin
					queue_result(ST_INVALID, '0, '0, 1'b1);
				end else begin
					// a slot that is already free stays as it is, the count still moves
					if (links[id] == '0) begin
						links[id] = links[0];
						links[0]  = ID_W'(id);
					end
					change_count++;
					queue_result(ST_OK, '0, '0, 1'b1);
				end
			end
			REQ_LOOKUP: begin
				if (id == '0 || id > n)
					queue_result(ST_INVALID, '0, '0, 1'b1);
				else if (links[id] != '0)
					queue_result(ST_FREE, '0, '0, 1'b1);
				else
					queue_result(ST_OK, '0, slot_address(id), 1'b1);
			end
			REQ_LIST: begin
				listed = 0;
				for (int i = 1; i <= n && listed < LIST_MAX; i++) begin
					if (links[i] == '0) begin
						queue_result(ST_OK, ID_W'(i), '0, 1'b0);
						listed++;
					end
				end
				if (listed == 0) begin
					queue_result(ST_NONE, '0, '0, 1'b1);
				end else begin
					r = due_results[due_results.size() - 1];
					r.last = 1'b1;
					due_results[due_results.size() - 1] = r;
				end
				if (listed > longest_list)
					longest_list = listed;
			end
			REQ_REINIT: begin
				relink();
				queue_result(ST_OK, '0, '0, 1'b1);
			end
			default: ;
			endcase
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
						$time, name, want, got);
			end
		endfunction

		function void check_result(logic [ST_W-1:0] st, logic [ID_W-1:0] id,
			logic [ADDR_W-1:0] addr, logic [VER_W-1:0] ver, logic last);
			slot_result_t want;
			results++;
			if (due_results.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t ns: result without request, expected none, actual status %0d slot %0d",
						$time, st, id);
				return;
			end
			want = due_results.pop_front();
			compare_field("status", want.status, st);
			compare_field("slot_id_res", want.slot_id, id);
			compare_field("address", want.address, addr);
			compare_field("version", want.version, ver);
			compare_field("last", want.last, last);
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	int unsigned src_idle_pct = 30;
	int unsigned sink_idle_pct = 80;
	int unsigned hold_left = 0;
	logic        hold_done = 1'b0;
	logic        hold_start = 1'b0;
	int unsigned idle_cycles = 0;

	slot_pool_scoreboard sb;

	sfla_req_if req_if ();
	sfla_rsp_if rsp_if ();

	slot_free_list_allocator_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_if),
		.rsp       (rsp_if),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always #2 clk = ~clk;

	// Result side: random stalls, plus one long hold-off on request.
	always @(posedge clk) begin
		if (hold_left != 0) begin
			rsp_if.ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_start && !hold_done) begin
			rsp_if.ready <= 1'b0;
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else begin
			rsp_if.ready <= ($urandom_range(99) >= sink_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (req_if.valid && req_if.ready)
				sb.note_request(req_if.req_type, req_if.slot_id);
			if (rsp_if.valid && rsp_if.ready)
				sb.check_result(rsp_if.status, rsp_if.slot_id_res, rsp_if.address,
					rsp_if.version, rsp_if.last);
			if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles == STALL_LIMIT) begin
				$display("%0t ns: no handshake for %0d cycles, %0d results outstanding",
					$time, STALL_LIMIT, sb.due_results.size());
				$display("Regression FAIL");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	task automatic send_req(input logic [REQ_W-1:0] kind, input logic [SID_W-1:0] id);
		while ($urandom_range(99) < src_idle_pct) begin
			req_if.valid <= 1'b0;
			@(posedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.req_type <= kind;
		req_if.slot_id <= id;
		@(posedge clk);
		while (!req_if.ready)
			@(posedge clk);
	endtask

	// Drop valid, wait for every outstanding result, then let the block settle.
	task automatic drain_block(input int unsigned settle);
		req_if.valid <= 1'b0;
		// let the monitor note the request taken at the last edge
		@(posedge clk);
		while (sb.due_results.size() != 0)
			@(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	task automatic write_cfg(input logic [SIZE_W-1:0] size, input logic [ID_W-1:0] count,
		input logic [ADDR_W-1:0] base);
		logic [CFG_DATA_W-1:0] size_word;
		logic [CFG_DATA_W-1:0] count_word;
		size_word = {16'($urandom), size};
		count_word = {26'($urandom), count};
		cfg_we <= 1'b1;
		cfg_index <= REG_SLOT_SIZE;
		cfg_wdata <= size_word;
		@(posedge clk);
		cfg_index <= REG_SLOT_COUNT;
		cfg_wdata <= count_word;
		@(posedge clk);
		cfg_index <= REG_BASE_ADDR;
		cfg_wdata <= base;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.write_reg(REG_SLOT_SIZE, size_word);
		sb.write_reg(REG_SLOT_COUNT, count_word);
		sb.write_reg(REG_BASE_ADDR, base);
	endtask

	initial begin
		int unsigned      pick;
		int unsigned      n;
		logic [REQ_W-1:0] kind;
		logic [SID_W-1:0] id;

		sb = new();
		arst_n = 1'b0;
		req_if.valid = 1'b0;
		req_if.req_type = REQ_ALLOC;
		req_if.slot_id = '0;
		rsp_if.ready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_SLOT_SIZE;
		cfg_wdata = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty pool, rejected ids, double free, unused types, reinit
		send_req(REQ_LIST, 8'h00);
		send_req(REQ_LOOKUP, 8'd0);
		send_req(REQ_LOOKUP, 8'd1);
		send_req(REQ_FREE, 8'd0);
		send_req(REQ_FREE, 8'hFF);
		send_req(REQ_FREE, 8'd33);
		send_req(REQ_ALLOC, 8'hFF);
		send_req(REQ_ALLOC, 8'h00);
		send_req(REQ_LOOKUP, 8'd2);
		send_req(REQ_FREE, 8'd2);
		send_req(REQ_FREE, 8'd2);
		send_req(REQ_LIST, 8'hAA);
		send_req(REQ_UNUSED_LO, 8'd1);
		send_req(REQ_UNUSED_HI, 8'd1);
		send_req(REQ_REINIT, 8'h55);
		send_req(REQ_LIST, 8'h00);

		// saturated count, addresses that wrap past 2^32
		drain_block(SETTLE_CYCLES);
		write_cfg(16'hFFFF, 6'h3F, 32'hFFFF_FFFF);
		send_req(REQ_ALLOC, 8'h00);
		send_req(REQ_ALLOC, 8'h00);
		send_req(REQ_LOOKUP, 8'd2);
		send_req(REQ_LOOKUP, 8'd63);
		send_req(REQ_LOOKUP, 8'd32);

		// zero slots: everything is refused
		drain_block(SETTLE_CYCLES);
		write_cfg(16'h8000, 6'd0, 32'hAAAA_5555);
		send_req(REQ_ALLOC, 8'h00);
		send_req(REQ_FREE, 8'd1);
		send_req(REQ_LOOKUP, 8'd1);
		send_req(REQ_LIST, 8'h00);

		drain_block(SETTLE_CYCLES);
		write_cfg(16'h0001, 6'd1, 32'h0000_0000);
		send_req(REQ_REINIT, 8'h00);
		send_req(REQ_ALLOC, 8'h00);
		send_req(REQ_ALLOC, 8'h00);

		for (int ph = 0; ph < 6; ph++) begin
			drain_block(SETTLE_CYCLES);
			case (ph)
			0: begin
				src_idle_pct = 30;
				sink_idle_pct = 80;
				write_cfg(16'd64, 6'd32, 32'h0000_1000);
			end
			1: write_cfg(16'd1, 6'd1, 32'hFFFF_FFFF);
			2: begin
				src_idle_pct = 80;
				sink_idle_pct = 30;
				write_cfg(16'hFFFF, 6'd32, 32'hFFFF_0000);
			end
			3: write_cfg(16'($urandom), 6'd0, $urandom);
			4: begin
				src_idle_pct = 0;
				sink_idle_pct = 0;
				write_cfg(16'($urandom), 6'h3F, $urandom);
			end
			default: begin
				write_cfg(16'($urandom_range(1, 65535)), 6'($urandom_range(2, 31)), $urandom);
				// stall results for a long stretch while requests keep coming
				hold_start <= 1'b1;
			end
			endcase

			// exhaust the pool, then walk it
			repeat (sb.active_slots() + 1) send_req(REQ_ALLOC, SID_W'($urandom));
			send_req(REQ_LIST, SID_W'($urandom));

			for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
				pick = $urandom_range(99);
				n = sb.active_slots();
				if ($urandom_range(99) < 85)
					id = SID_W'($urandom_range(0, n + 1));
				else
					id = SID_W'($urandom);
				if (pick < 38)
					kind = REQ_ALLOC;
				else if (pick < 62)
					kind = REQ_FREE;
				else if (pick < 82)
					kind = REQ_LOOKUP;
				else if (pick < 89)
					kind = REQ_LIST;
				else if (pick < 93)
					kind = REQ_REINIT;
				else
					kind = REQ_W'($urandom_range(REQ_UNUSED_LO, REQ_UNUSED_HI));
				send_req(kind, id);
			end
		end

		drain_block(TAIL_CYCLES);
		$display("Checked %0d requests and %0d results over directed cases and six slot setups,",
			sb.requests, sb.results);
		$display("stalls on both sides and a long result hold-off; longest list %0d, %0d allocs refused.",
			sb.longest_list, sb.refused_allocs);
		if (sb.errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
